>>> design/pdw_pkg.sv
package pdw_pkg;

  // Window geometry
  localparam int CAPACITY = 128;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int OCC_W    = $clog2(CAPACITY + 1);
  localparam int DIG_W    = 160;

  // Register and field constants
  localparam logic [7:0] LIMIT_RESET = 8'd100;
  localparam logic [1:0] KIND_DATA   = 2'd1;

  // Verdict codes
  localparam logic [1:0] VERDICT_NEW     = 2'd0;
  localparam logic [1:0] VERDICT_DUP     = 2'd1;
  localparam logic [1:0] VERDICT_IGNORED = 2'd2;

  typedef logic [DIG_W-1:0] digest_t;
  typedef logic [IDX_W-1:0] slot_t;
  typedef logic [OCC_W-1:0] occ_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_UPDATE,
    ST_APPEND,
    ST_DONE
  } state_t;

  // Memory port controls from the sequencer
  typedef struct packed {
    logic    dig_we;
    logic    rank_we;
    slot_t   waddr;
    slot_t   raddr;
    digest_t wdig;
    slot_t   wrank;
  } mem_req_t;

endpackage

>>> design/pdw_ram.sv
module pdw_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> design/pdw_seq.sv
module pdw_seq
  import pdw_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic [31:0] digest_high,
  input  logic [63:0] digest_mid,
  input  logic [63:0] digest_low,
  input  logic [1:0]  frame_kind,
  input  logic        packet_empty,
  input  logic        in_valid,
  output logic        in_stall,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  verdict,
  input  occ_t        limit,
  input  digest_t     dig_q,
  input  slot_t       rank_q,
  output mem_req_t    req
);

  state_t   state;
  state_t   state_next;
  digest_t  key;
  logic [1:0] verd;
  occ_t     occ;
  occ_t     idx;
  logic     pend;
  slot_t    pend_addr;
  slot_t    rnk;

  logic accept;
  logic ignore;
  logic match;
  logic last;
  logic issue;
  logic load;
  logic full;

  assign accept = in_valid && !in_stall;
  assign ignore = packet_empty || (frame_kind != KIND_DATA);
  assign match  = (dig_q == key);
  assign last   = (OCC_W'(pend_addr) == occ - OCC_W'(1));
  assign issue  = (idx < occ);
  assign load   = !out_valid || !out_stall;
  assign full   = (occ >= limit);
  assign in_stall = (state != ST_IDLE);

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          if (ignore) begin
            state_next = ST_DONE;
          end else if (occ == '0) begin
            state_next = ST_APPEND;
          end else begin
            state_next = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (pend && match) begin
          state_next = ST_UPDATE;
        end else if (pend && last) begin
          state_next = full ? ST_UPDATE : ST_APPEND;
        end
      end
      ST_UPDATE: begin
        if (pend && last) begin
          state_next = ST_DONE;
        end
      end
      ST_APPEND: state_next = ST_DONE;
      ST_DONE: begin
        if (load) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Memory port controls. The rewrite sweep closes the gap at the removed
  // rank and gives the touched slot the newest rank.
  always_comb begin
    req       = '0;
    req.raddr = idx[IDX_W-1:0];
    req.wdig  = key;
    case (state)
      ST_UPDATE: begin
        req.waddr   = pend_addr;
        req.dig_we  = pend && (rank_q == rnk);
        req.rank_we = pend && (rank_q >= rnk);
        req.wrank   = (rank_q == rnk) ? IDX_W'(occ - OCC_W'(1)) : rank_q - IDX_W'(1);
      end
      ST_APPEND: begin
        req.waddr   = occ[IDX_W-1:0];
        req.dig_we  = 1'b1;
        req.rank_we = 1'b1;
        req.wrank   = occ[IDX_W-1:0];
      end
      default: begin
        req.dig_we  = 1'b0;
        req.rank_we = 1'b0;
      end
    endcase
  end

  // State and window occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      occ   <= '0;
      pend  <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_APPEND) begin
        occ <= occ + OCC_W'(1);
      end
      case (state)
        ST_SCAN: begin
          if ((pend && match) || (pend && last)) begin
            pend <= 1'b0;
          end else begin
            pend <= issue;
          end
        end
        ST_UPDATE: begin
          if (pend && last) begin
            pend <= 1'b0;
          end else begin
            pend <= issue;
          end
        end
        default: pend <= 1'b0;
      endcase
    end
  end

  // Item key, sweep counter and removed rank
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (accept) begin
          key  <= {digest_high, digest_mid, digest_low};
          verd <= ignore ? VERDICT_IGNORED : VERDICT_NEW;
          idx  <= '0;
        end
      end
      ST_SCAN: begin
        if (pend && match) begin
          rnk  <= rank_q;
          verd <= VERDICT_DUP;
          idx  <= '0;
        end else if (pend && last) begin
          rnk <= '0;
          idx <= '0;
        end else begin
          pend_addr <= idx[IDX_W-1:0];
          if (issue) begin
            idx <= idx + OCC_W'(1);
          end
        end
      end
      ST_UPDATE: begin
        pend_addr <= idx[IDX_W-1:0];
        if (issue) begin
          idx <= idx + OCC_W'(1);
        end
      end
      default: begin
        idx <= idx;
      end
    endcase
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((state == ST_DONE) && load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == ST_DONE) && load) begin
      verdict <= verd;
    end
  end

endmodule

>>> design/packet_duplicate_window.sv
// Flow: an ignored packet goes straight to the result register once its beat is taken;
// a looked-up packet goes straight to the append step if the window is empty, else the
// window is scanned, then the packet is appended on a miss with room or a rank rewrite sweep follows.
// Throughput: one packet at a time; the scan and rank rewrite step one slot per cycle
// through the single read port of the digest and rank memories.
// Reset: window empty, window_limit 100, no result held; no clearing pass is needed.
module packet_duplicate_window
  import pdw_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        wr_en,
  input  logic [7:0]  wr_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] digest_high,
  input  logic [63:0] digest_mid,
  input  logic [63:0] digest_low,
  input  logic [1:0]  frame_kind,
  input  logic        packet_empty,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  verdict
);

  logic [7:0] window_limit;
  occ_t       limit;
  mem_req_t   req;
  digest_t    dig_q;
  slot_t      rank_q;

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      window_limit <= LIMIT_RESET;
    end else if (wr_en) begin
      window_limit <= wr_data;
    end
  end

  // Zero acts as one, and anything above the capacity as the capacity.
  always_comb begin
    if (window_limit == 8'd0) begin
      limit = OCC_W'(1);
    end else if (32'(window_limit) > CAPACITY) begin
      limit = OCC_W'(CAPACITY);
    end else begin
      limit = OCC_W'(window_limit);
    end
  end

  pdw_seq u_seq (
    .clk          (clk),
    .rst          (rst),
    .digest_high  (digest_high),
    .digest_mid   (digest_mid),
    .digest_low   (digest_low),
    .frame_kind   (frame_kind),
    .packet_empty (packet_empty),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .verdict      (verdict),
    .limit        (limit),
    .dig_q        (dig_q),
    .rank_q       (rank_q),
    .req          (req)
  );

  // Digest of each slot
  pdw_ram #(.WIDTH(DIG_W), .DEPTH(CAPACITY)) u_dig_ram (
    .clk   (clk),
    .we    (req.dig_we),
    .waddr (req.waddr),
    .wdata (req.wdig),
    .raddr (req.raddr),
    .rdata (dig_q)
  );

  // Recency rank of each slot, zero being the oldest
  pdw_ram #(.WIDTH(IDX_W), .DEPTH(CAPACITY)) u_rank_ram (
    .clk   (clk),
    .we    (req.rank_we),
    .waddr (req.waddr),
    .wdata (req.wrank),
    .raddr (req.raddr),
    .rdata (rank_q)
  );

endmodule

>>> design/pdw_checker.sv
module pdw_checker
  import pdw_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_stall,
  input logic [1:0]  frame_kind,
  input logic        packet_empty,
  input logic        out_valid,
  input logic        out_stall,
  input logic [1:0]  verdict
);

  // A stalled result beat holds its verdict.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(verdict))
    else $error("stalled verdict changed");

  // No result is left over from before reset.
  assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("result valid after reset");

  // One packet at a time: an accepted beat is followed by a stall.
  assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("second packet taken while busy");

  // An ignored packet reaches an empty output as ignored.
  assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && !out_valid && (packet_empty || frame_kind != KIND_DATA)
    |-> ##2 (out_valid && verdict == VERDICT_IGNORED))
    else $error("ignored packet verdict missing");

endmodule

bind packet_duplicate_window pdw_checker u_pdw_checker (.*);

>>> tb/packet_duplicate_window_tb.sv
`timescale 1ns / 100ps

module packet_duplicate_window_tb;
  import pdw_pkg::*;

  // Software copy of the recency window, oldest digest at position 0.
  class dedup_window_model;
    digest_t    cells[$];
    int         limit_reg;
    logic [1:0] verdicts_due[$];
    int         errors;

    function new();
      limit_reg = LIMIT_RESET;
      errors = 0;
    endfunction

    function void write_limit(logic [7:0] value);
      limit_reg = value;
    endfunction

    // Work out the verdict for an accepted beat and update the window.
    function void note_packet(digest_t dig, logic [1:0] kind, logic empty);
      int lim;
      int hit_pos;
      hit_pos = -1;
      if (empty || kind != KIND_DATA) begin
        verdicts_due.push_back(VERDICT_IGNORED);
        return;
      end
      lim = limit_reg;
      if (lim < 1) lim = 1;
      if (lim > CAPACITY) lim = CAPACITY;
      foreach (cells[i]) begin
        if (hit_pos < 0 && cells[i] == dig) hit_pos = i;
      end
      if (hit_pos >= 0) begin
        cells.delete(hit_pos);
      end else if (cells.size() > 0 && cells.size() >= lim) begin
        cells.delete(0);
      end
      if (cells.size() < CAPACITY) cells.push_back(dig);
      verdicts_due.push_back(hit_pos >= 0 ? VERDICT_DUP : VERDICT_NEW);
    endfunction

    // Compare a result beat with the oldest outstanding verdict.
    function void check_verdict(logic [1:0] got);
      logic [1:0] want;
      if (verdicts_due.size() == 0) begin
        $display("%0t: unexpected verdict beat, expected none, actual %0d", $time, got);
        errors++;
        return;
      end
      want = verdicts_due.pop_front();
      if (got !== want) begin
        $display("%0t: verdict mismatch, expected %0d, actual %0d", $time, want, got);
        errors++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        wr_en;
  logic [7:0]  wr_data;
  logic        in_valid;
  logic        in_stall;
  logic [31:0] digest_high;
  logic [63:0] digest_mid;
  logic [63:0] digest_low;
  logic [1:0]  frame_kind;
  logic        packet_empty;
  logic        out_valid;
  logic        out_stall;
  logic [1:0]  verdict;

  dedup_window_model window_model = new();
  digest_t           recent_digests[$];
  bit                stimulus_done;

  packet_duplicate_window DUT (
    .clk(clk), .rst(rst), .wr_en(wr_en), .wr_data(wr_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .digest_high(digest_high), .digest_mid(digest_mid), .digest_low(digest_low),
    .frame_kind(frame_kind), .packet_empty(packet_empty),
    .out_valid(out_valid), .out_stall(out_stall), .verdict(verdict)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Send one packet beat and hold it until it is taken. The task returns at the
  // falling edge after the beat, with valid still high until the next call or a
  // caller drops it.
  task automatic send_packet(digest_t dig, logic [1:0] kind, logic empty);
    int gap;
    gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid     <= 1'b1;
    digest_high  <= dig[159:128];
    digest_mid   <= dig[127:64];
    digest_low   <= dig[63:0];
    frame_kind   <= kind;
    packet_empty <= empty;
    do @(posedge clk); while (in_stall);
    window_model.note_packet(dig, kind, empty);
    @(negedge clk);
  endtask

  // Write window_limit once the block has drained.
  task automatic set_limit(logic [7:0] value);
    in_valid <= 1'b0;
    while (window_model.verdicts_due.size() != 0) @(negedge clk);
    repeat (2 * CAPACITY + 10) @(negedge clk);
    wr_en   <= 1'b1;
    wr_data <= value;
    @(posedge clk);
    window_model.write_limit(value);
    @(negedge clk);
    wr_en <= 1'b0;
  endtask

  function automatic digest_t random_digest();
    return {$urandom, $urandom, $urandom, $urandom, $urandom};
  endfunction

  // Mostly data packets, reusing recent digests often enough to hit.
  task automatic random_packets(int count, int pool);
    digest_t dig;
    int sel;
    repeat (count) begin
      sel = $urandom_range(0, 99);
      if (recent_digests.size() > 0 && sel < 45)
        dig = recent_digests[$urandom_range(0, recent_digests.size() - 1)];
      else begin
        dig = random_digest();
        if (sel > 95) dig = '1;
        if (sel == 95) dig = '0;
        recent_digests.push_back(dig);
        if (recent_digests.size() > pool) recent_digests.delete(0);
      end
      if ($urandom_range(0, 9) < 8) send_packet(dig, KIND_DATA, 1'b0);
      else send_packet(dig, 2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)));
    end
  endtask

  // Result side: stall for a random number of cycles per beat, then take it.
  initial begin
    int wait_cycles;
    out_stall = 1'b1;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      wait_cycles = $urandom_range(0, 11);
      if (wait_cycles > 0) begin
        out_stall <= 1'b1;
        repeat (wait_cycles) @(negedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
      window_model.check_verdict(verdict);
      @(negedge clk);
    end
  end

  initial begin
    digest_t d;
    rst = 1'b1;
    wr_en = 1'b0;
    wr_data = '0;
    in_valid = 1'b0;
    digest_high = '0;
    digest_mid = '0;
    digest_low = '0;
    frame_kind = '0;
    packet_empty = 1'b0;
    stimulus_done = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: extremes of the digest, every kind, empty packets, hits.
    send_packet('0, KIND_DATA, 1'b0);
    send_packet('1, KIND_DATA, 1'b0);
    send_packet('0, KIND_DATA, 1'b0);
    send_packet('1, 2'd0, 1'b0);
    send_packet('1, 2'd2, 1'b0);
    send_packet('1, 2'd3, 1'b0);
    send_packet('1, KIND_DATA, 1'b1);
    send_packet('1, KIND_DATA, 1'b0);
    d = random_digest();
    send_packet(d, KIND_DATA, 1'b0);
    send_packet(d, KIND_DATA, 1'b0);

    // Limit of zero acts as one.
    set_limit(8'd0);
    send_packet('0, KIND_DATA, 1'b0);
    send_packet('1, KIND_DATA, 1'b0);
    send_packet('0, KIND_DATA, 1'b0);

    // Limit above capacity acts as capacity.
    set_limit(8'd255);
    random_packets(300, 160);

    // Limit lowered below occupancy.
    set_limit(8'd3);
    random_packets(250, 8);
    set_limit(8'd128);
    random_packets(350, 150);
    set_limit(8'd1);
    random_packets(150, 3);
    set_limit(8'd16);
    random_packets(300, 24);
    set_limit(8'd100);
    random_packets(480, 120);

    in_valid <= 1'b0;
    stimulus_done = 1'b1;
    while (window_model.verdicts_due.size() != 0) @(negedge clk);
    repeat (2 * CAPACITY + 20) @(negedge clk);
    if (window_model.errors == 0 && window_model.verdicts_due.size() == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Hard stop well beyond the slowest legal run.
  initial begin
    #40_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

>>> files.f
design/pdw_pkg.sv
design/pdw_ram.sv
design/pdw_seq.sv
design/packet_duplicate_window.sv
design/pdw_checker.sv
tb/packet_duplicate_window_tb.sv
